// ===== hdl/scx_pkg.sv =====
`timescale 1ns / 1ps

package scx_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int TOL_W       = 16;
    // a coordinate difference needs one bit more than a coordinate
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int CMP_W       = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;
    localparam int LT_W        = ((COORD_WIDTH > TOL_W) ? COORD_WIDTH : TOL_W) + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [CROSS_W-1:0]     t_cross;
    typedef logic        [TOL_W-1:0]       t_tol;

    // one classified pair on its way from the front to the back
    typedef struct packed {
        logic  reject;
        t_diff s1x;
        t_diff s1y;
        t_diff s2x;
        t_diff s2y;
        t_diff wx;
        t_diff wy;
    } t_job;

endpackage

// ===== hdl/scx_front.sv =====
`timescale 1ns / 1ps

module scx_front import scx_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    output logic   o_ready,
    input  t_tol   i_tol,
    input  t_coord i_p0x,
    input  t_coord i_p0y,
    input  t_coord i_p1x,
    input  t_coord i_p1y,
    input  t_coord i_p2x,
    input  t_coord i_p2y,
    input  t_coord i_p3x,
    input  t_coord i_p3y,
    output logic   o_job_valid,
    output t_job   o_job,
    input  logic   i_job_ready
);

    typedef logic signed [LT_W-1:0] t_lt;

    logic   r_valid;
    t_coord r_p0x, r_p0y, r_p1x, r_p1y, r_p2x, r_p2y, r_p3x, r_p3y;
    logic   shared_end;
    logic   box_apart;

    function automatic logic near_eq(t_coord a, t_coord b, t_tol tol);
        t_diff              d;
        t_diff              ad;
        logic [CMP_W-1:0]   m;
        logic [CMP_W-1:0]   t;
        d  = t_diff'(a) - t_diff'(b);
        ad = d[DIFF_W-1] ? -d : d;
        // magnitude of the most negative difference still reads right unsigned
        m  = CMP_W'(unsigned'(ad));
        t  = CMP_W'(tol);
        return m <= t;
    endfunction

    function automatic logic less_tol(t_coord a, t_coord b, t_tol tol);
        t_lt ea;
        t_lt eb;
        t_lt et;
        ea = t_lt'(a);
        eb = t_lt'(b);
        et = t_lt'(tol);
        return (ea + et) < eb;
    endfunction

    function automatic t_coord cmax(t_coord a, t_coord b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_coord cmin(t_coord a, t_coord b);
        return (a > b) ? b : a;
    endfunction

    assign o_ready     = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && o_ready) begin
            r_p0x <= i_p0x;
            r_p0y <= i_p0y;
            r_p1x <= i_p1x;
            r_p1y <= i_p1y;
            r_p2x <= i_p2x;
            r_p2y <= i_p2y;
            r_p3x <= i_p3x;
            r_p3y <= i_p3y;
        end
    end

    always_comb begin
        shared_end =
            (near_eq(r_p2x, r_p0x, i_tol) && near_eq(r_p2y, r_p0y, i_tol)) ||
            (near_eq(r_p3x, r_p1x, i_tol) && near_eq(r_p3y, r_p1y, i_tol)) ||
            (near_eq(r_p2x, r_p1x, i_tol) && near_eq(r_p2y, r_p1y, i_tol)) ||
            (near_eq(r_p3x, r_p0x, i_tol) && near_eq(r_p3y, r_p0y, i_tol));
        box_apart =
            less_tol(cmax(r_p0x, r_p1x), cmin(r_p2x, r_p3x), i_tol) ||
            less_tol(cmax(r_p2x, r_p3x), cmin(r_p0x, r_p1x), i_tol) ||
            less_tol(cmax(r_p0y, r_p1y), cmin(r_p2y, r_p3y), i_tol) ||
            less_tol(cmax(r_p2y, r_p3y), cmin(r_p0y, r_p1y), i_tol);

        o_job.reject = shared_end || box_apart;
        o_job.s1x    = t_diff'(r_p1x) - t_diff'(r_p0x);
        o_job.s1y    = t_diff'(r_p1y) - t_diff'(r_p0y);
        o_job.s2x    = t_diff'(r_p3x) - t_diff'(r_p2x);
        o_job.s2y    = t_diff'(r_p3y) - t_diff'(r_p2y);
        o_job.wx     = t_diff'(r_p0x) - t_diff'(r_p2x);
        o_job.wy     = t_diff'(r_p0y) - t_diff'(r_p2y);
    end

endmodule

// ===== hdl/scx_queue.sv =====
`timescale 1ns / 1ps

module scx_queue import scx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_ready,
    output logic o_valid,
    output t_job o_data,
    input  logic i_pop
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/scx_back.sv =====
`timescale 1ns / 1ps

module scx_back import scx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_pop,
    output logic o_done,
    output logic o_cross
);

    // stage 1: six cross-product terms
    logic   r_m_valid;
    logic   r_m_reject;
    t_prod  r_den_a, r_den_b, r_sn_a, r_sn_b, r_tn_a, r_tn_b;
    // stage 2: denominator and both numerators
    logic   r_s_valid;
    logic   r_s_reject;
    t_cross r_den, r_sn, r_tn;
    // stage 3: result
    logic   r_done;
    logic   r_cross;
    logic   n_cross;
    logic   den_neg;
    logic   in_pos;
    logic   in_neg;

    // the back never stalls, so every queued job is taken at once
    assign o_pop = i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_m_valid <= i_job_valid;
            r_s_valid <= r_m_valid;
            r_done    <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_reject <= i_job.reject;
        r_den_a    <= t_prod'(i_job.s1x) * t_prod'(i_job.s2y);
        r_den_b    <= t_prod'(i_job.s2x) * t_prod'(i_job.s1y);
        r_sn_a     <= t_prod'(i_job.s1x) * t_prod'(i_job.wy);
        r_sn_b     <= t_prod'(i_job.s1y) * t_prod'(i_job.wx);
        r_tn_a     <= t_prod'(i_job.s2x) * t_prod'(i_job.wy);
        r_tn_b     <= t_prod'(i_job.s2y) * t_prod'(i_job.wx);

        r_s_reject <= r_m_reject;
        r_den      <= t_cross'(r_den_a) - t_cross'(r_den_b);
        r_sn       <= t_cross'(r_sn_a) - t_cross'(r_sn_b);
        r_tn       <= t_cross'(r_tn_a) - t_cross'(r_tn_b);

        r_cross    <= n_cross;
    end

    // ratio in [0,1] without dividing: compare against den on its own sign
    always_comb begin
        den_neg = r_den[CROSS_W-1];
        in_pos  = !r_sn[CROSS_W-1] && (r_sn <= r_den) &&
                  !r_tn[CROSS_W-1] && (r_tn <= r_den);
        in_neg  = (r_sn <= t_cross'(0)) && (r_sn >= r_den) &&
                  (r_tn <= t_cross'(0)) && (r_tn >= r_den);
        n_cross = r_s_valid && !r_s_reject && (r_den != t_cross'(0)) &&
                  (den_neg ? in_neg : in_pos);
    end

    assign o_done  = r_done;
    assign o_cross = r_cross;

endmodule

// ===== hdl/segment_crossing_test.sv =====
`timescale 1ns / 1ps
// channel   ports                                   handshake
// config    i_cfg_wr_en, i_cfg_wr_data              written when i_cfg_wr_en is high
// pair in   i_a_*, i_b_* (start/end x/y)            beat taken when start && !busy
// result    o_segments_cross                        one cycle, marked by o_done
//
// a pair is taken every cycle; its o_done follows once the pair has passed the stages of the path below
// path: input register, classify into a 2-entry queue, multiply, combine, compare
// the back drains the queue every cycle, so busy only rises if the queue fills
// synchronous active-low reset clears the tolerance to 0 and empties the pipeline
// the receiver cannot stall: o_done is a single-cycle strobe

module segment_crossing_test import scx_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_wr_en,
    input  t_tol   i_cfg_wr_data,
    input  logic   start,
    output logic   busy,
    input  t_coord i_a_start_x,
    input  t_coord i_a_start_y,
    input  t_coord i_a_end_x,
    input  t_coord i_a_end_y,
    input  t_coord i_b_start_x,
    input  t_coord i_b_start_y,
    input  t_coord i_b_end_x,
    input  t_coord i_b_end_y,
    output logic   o_done,
    output logic   o_segments_cross
);

    t_tol r_tol;
    logic front_ready;
    logic job_valid;
    t_job job;
    logic q_ready;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    assign busy = !front_ready;

    scx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_ready     (front_ready),
        .i_tol       (r_tol),
        .i_p0x       (i_a_start_x),
        .i_p0y       (i_a_start_y),
        .i_p1x       (i_a_end_x),
        .i_p1y       (i_a_end_y),
        .i_p2x       (i_b_start_x),
        .i_p2y       (i_b_start_y),
        .i_p3x       (i_b_end_x),
        .i_p3y       (i_b_end_y),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (q_ready)
    );

    scx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_job),
        .i_pop   (q_pop)
    );

    scx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_done      (o_done),
        .o_cross     (o_segments_cross)
    );

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_done)
        else $error("taken pair did not finish after five cycles");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 5))
        else $error("result without a matching taken pair");

    a_cross_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_segments_cross |-> o_done)
        else $error("crossing flag raised outside a result beat");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("queue filled although the back drains every cycle");

endmodule
